// ----- design/tgb_pkg.sv -----
// Shared types, constants and the 5x7 font table of the text glyph blitter.
// No dependencies; every other design file but tgb_fifo imports this package.
package tgb_pkg;

  localparam int CUR_W          = 13;
  localparam int CHAR_W         = 8;
  localparam int INK_W          = 32;
  localparam int ADDR_W         = 22;
  localparam int CFG_W          = 12;
  localparam int GLYPH_COLS     = 5;
  localparam int GLYPH_ROWS     = 7;
  localparam int DEF_MAX_FB_DIM = 2048;
  localparam int DEF_CMD_DEPTH  = 2;
  localparam int DEF_OUT_DEPTH  = 4;
  localparam int CHAR_ADVANCE   = 6;

  localparam logic [CUR_W-1:0] CURSOR_MAX     = 13'd4095;
  localparam logic [CFG_W-1:0] FB_WIDTH_RST   = 12'd640;
  localparam logic [CFG_W-1:0] FB_HEIGHT_RST  = 12'd480;

  localparam logic CFG_IDX_WIDTH   = 1'b0;
  localparam logic CFG_IDX_HEIGHT  = 1'b1;
  localparam logic FUNC_SET_CURSOR = 1'b0;
  localparam logic FUNC_DRAW       = 1'b1;

  typedef logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] glyph_t;

  typedef struct packed {
    logic signed [CUR_W-1:0] col;
    logic signed [CUR_W-1:0] row;
    glyph_t                  glyph;
    logic [INK_W-1:0]        ink;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [INK_W-1:0]  color;
    logic              last;
  } pix_t;

  function automatic glyph_t pack5(input logic [7:0] c0, input logic [7:0] c1,
                                   input logic [7:0] c2, input logic [7:0] c3,
                                   input logic [7:0] c4);
    return {c4[6:0], c3[6:0], c2[6:0], c1[6:0], c0[6:0]};
  endfunction

  // Column bitmaps, bit 0 is the top row. Lowercase maps to uppercase.
  function automatic glyph_t font_glyph(input logic [CHAR_W-1:0] code);
    logic [CHAR_W-1:0] u;
    glyph_t            g;
    u = code;
    if (code inside {[8'h61:8'h7A]}) begin
      u = code - 8'h20;
    end
    case (u)
      8'h30: g = pack5(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
      8'h31: g = pack5(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
      8'h32: g = pack5(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
      8'h33: g = pack5(8'h22, 8'h41, 8'h49, 8'h49, 8'h36);
      8'h34: g = pack5(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
      8'h35: g = pack5(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
      8'h36: g = pack5(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h31);
      8'h37: g = pack5(8'h41, 8'h20, 8'h10, 8'h08, 8'h07);
      8'h38: g = pack5(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
      8'h39: g = pack5(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E);
      8'h41: g = pack5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
      8'h42: g = pack5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
      8'h43: g = pack5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
      8'h44: g = pack5(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C);
      8'h45: g = pack5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
      8'h46: g = pack5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01);
      8'h47: g = pack5(8'h3E, 8'h41, 8'h49, 8'h49, 8'h3A);
      8'h48: g = pack5(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
      8'h49: g = pack5(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
      8'h4A: g = pack5(8'h30, 8'h40, 8'h40, 8'h40, 8'h3F);
      8'h4B: g = pack5(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
      8'h4C: g = pack5(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
      8'h4D: g = pack5(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F);
      8'h4E: g = pack5(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
      8'h4F: g = pack5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
      8'h50: g = pack5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
      8'h51: g = pack5(8'h3E, 8'h51, 8'h51, 8'h51, 8'h2E);
      8'h52: g = pack5(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
      8'h53: g = pack5(8'h26, 8'h49, 8'h49, 8'h49, 8'h32);
      8'h54: g = pack5(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
      8'h55: g = pack5(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
      8'h56: g = pack5(8'h0F, 8'h30, 8'h40, 8'h30, 8'h0F);
      8'h57: g = pack5(8'h7F, 8'h20, 8'h10, 8'h20, 8'h7F);
      8'h58: g = pack5(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
      8'h59: g = pack5(8'h07, 8'h08, 8'h70, 8'h08, 8'h07);
      8'h5A: g = pack5(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
      8'h3A: g = pack5(8'h00, 8'h36, 8'h00, 8'h36, 8'h00);
      8'h2E: g = pack5(8'h00, 8'h00, 8'h00, 8'h00, 8'h40);
      8'h2D: g = pack5(8'h00, 8'h00, 8'h7F, 8'h00, 8'h00);
      8'h28: g = pack5(8'h0E, 8'h11, 8'h20, 8'h00, 8'h00);
      8'h29: g = pack5(8'h00, 8'h20, 8'h11, 8'h0E, 8'h00);
      8'h2F: g = pack5(8'h01, 8'h02, 8'h04, 8'h08, 8'h10);
      8'h2C: g = pack5(8'h00, 8'h00, 8'h00, 8'h20, 8'h10);
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// ----- design/tgb_fifo.sv -----
// Small register queue with occupancy count, used between blitter stages.
// Depends on nothing but its parameters.
module tgb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH-1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue occupancy above depth");
`endif

endmodule

// ----- design/tgb_front.sv -----
// Front end: takes items, keeps the text cursor and looks up glyphs.
// Depends on tgb_pkg; draw commands leave through a queue to tgb_back.
module tgb_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_func,
  input  logic [tgb_pkg::CHAR_W-1:0]     in_char_code,
  input  logic signed [tgb_pkg::CUR_W-1:0] in_pos_x,
  input  logic signed [tgb_pkg::CUR_W-1:0] in_pos_y,
  input  logic [tgb_pkg::INK_W-1:0]      in_ink_color,
  output logic                           cmd_push,
  output tgb_pkg::cmd_t                  cmd_data,
  input  logic                           cmd_full
);
  import tgb_pkg::*;

  logic signed [CUR_W-1:0] col_r, col_nxt;
  logic signed [CUR_W-1:0] row_r, row_nxt;
  logic signed [CUR_W:0]   adv;
  logic                    accept;

  assign in_full = cmd_full;
  assign accept  = in_push && !cmd_full;
  assign adv     = {col_r[CUR_W-1], col_r} + (CUR_W+1)'(CHAR_ADVANCE);

  assign cmd_push       = accept && (in_func == FUNC_DRAW);
  assign cmd_data.col   = col_r;
  assign cmd_data.row   = row_r;
  assign cmd_data.glyph = font_glyph(in_char_code);
  assign cmd_data.ink   = in_ink_color;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (in_func == FUNC_SET_CURSOR) begin
        col_nxt = in_pos_x;
        row_nxt = in_pos_y;
      end else if (adv > $signed({1'b0, CURSOR_MAX})) begin
        col_nxt = CURSOR_MAX;
      end else begin
        col_nxt = adv[CUR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ----- design/tgb_back.sv -----
// Back end: clips glyphs to the framebuffer; writes a pixel a cycle unless stalled.
// Depends on tgb_pkg and tgb_fifo; results leave through the output queue.
module tgb_back #(
  parameter int MAX_FB_DIM = tgb_pkg::DEF_MAX_FB_DIM,
  parameter int OUT_DEPTH  = tgb_pkg::DEF_OUT_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [$clog2(MAX_FB_DIM+1)-1:0] fb_w,
  input  logic [$clog2(MAX_FB_DIM+1)-1:0] fb_h,
  input  tgb_pkg::cmd_t                  cmd_data,
  input  logic                           cmd_empty,
  output logic                           cmd_pop,
  output logic                           out_empty,
  input  logic                           out_pop,
  output tgb_pkg::pix_t                  out_data
);
  import tgb_pkg::*;

  localparam int DIM_W  = $clog2(MAX_FB_DIM+1);
  localparam int CNT_W  = $clog2(OUT_DEPTH+1);
  localparam int COL_IW = $clog2(GLYPH_COLS);
  localparam int ROW_IW = $clog2(GLYPH_ROWS);
  localparam int SUM_W  = ADDR_W + 2*DIM_W;

  glyph_t                  mask_r, mask_nxt, mask_clr, load_mask;
  logic signed [CUR_W-1:0] col_r, row_r;
  logic [INK_W-1:0]        ink_r;
  logic [COL_IW-1:0]       cs;
  logic [ROW_IW-1:0]       rs;
  logic                    issue, credit;
  logic signed [CUR_W:0]   px_sel, py_sel;
  logic signed [CUR_W:0]   px_c [GLYPH_COLS];
  logic signed [CUR_W:0]   py_c [GLYPH_ROWS];
  logic [GLYPH_COLS-1:0]   col_vis;
  logic [GLYPH_ROWS-1:0]   row_vis;

  logic                    s1_valid_r;
  logic [DIM_W-1:0]        s1_py_r, s1_px_r;
  logic [INK_W-1:0]        s1_ink_r;
  logic                    s1_last_r;

  logic [2*DIM_W-1:0]      prod;
  logic [SUM_W-1:0]        sum;
  pix_t                    pix;
  logic                    out_full;
  logic [CNT_W-1:0]        out_count;

  always_comb begin
    for (int c = 0; c < GLYPH_COLS; c++) begin
      px_c[c]    = {cmd_data.col[CUR_W-1], cmd_data.col} + (CUR_W+1)'(c);
      col_vis[c] = !px_c[c][CUR_W] && (px_c[c][CUR_W-1:0] < CUR_W'(fb_w));
    end
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      py_c[r]    = {cmd_data.row[CUR_W-1], cmd_data.row} + (CUR_W+1)'(r);
      row_vis[r] = !py_c[r][CUR_W] && (py_c[r][CUR_W-1:0] < CUR_W'(fb_h));
    end
    for (int c = 0; c < GLYPH_COLS; c++) begin
      load_mask[c] = col_vis[c] ? (cmd_data.glyph[c] & row_vis) : '0;
    end
  end

  always_comb begin
    cs = '0;
    rs = '0;
    for (int c = GLYPH_COLS-1; c >= 0; c--) begin
      if (mask_r[c] != '0) begin
        cs = COL_IW'(c);
      end
    end
    for (int r = GLYPH_ROWS-1; r >= 0; r--) begin
      if (mask_r[cs][r]) begin
        rs = ROW_IW'(r);
      end
    end
    mask_clr         = mask_r;
    mask_clr[cs][rs] = 1'b0;
  end

  assign credit   = ({1'b0, out_count} + (CNT_W+1)'(s1_valid_r)) < (CNT_W+1)'(OUT_DEPTH);
  assign issue    = (mask_r != '0) && credit;
  assign cmd_pop  = !cmd_empty && (issue ? (mask_clr == '0) : (mask_r == '0));
  assign mask_nxt = cmd_pop ? load_mask : (issue ? mask_clr : mask_r);
  assign px_sel   = {col_r[CUR_W-1], col_r} + (CUR_W+1)'(cs);
  assign py_sel   = {row_r[CUR_W-1], row_r} + (CUR_W+1)'(rs);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      mask_r     <= mask_nxt;
      s1_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      col_r <= cmd_data.col;
      row_r <= cmd_data.row;
      ink_r <= cmd_data.ink;
    end
    if (issue) begin
      s1_px_r   <= px_sel[DIM_W-1:0];
      s1_py_r   <= py_sel[DIM_W-1:0];
      s1_ink_r  <= ink_r;
      s1_last_r <= (mask_clr == '0);
    end
  end

  assign prod      = s1_py_r * fb_w;
  assign sum       = SUM_W'(prod) + SUM_W'(s1_px_r);
  assign pix.addr  = sum[ADDR_W-1:0];
  assign pix.color = s1_ink_r;
  assign pix.last  = s1_last_r;

  tgb_fifo #(
    .WIDTH ($bits(pix_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (s1_valid_r),
    .din   (pix),
    .pop   (out_pop),
    .dout  (out_data),
    .full  (out_full),
    .empty (out_empty),
    .count (out_count)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> !out_full)
    else $error("pixel write pushed into a full output queue");
  a_issue_lands: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> ##2 !out_empty)
    else $error("issued pixel did not reach the output queue");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop && issue |-> s1_last_r || !s1_valid_r || mask_clr == '0)
    else $error("new glyph loaded while pixels of the previous one remain");
`endif

endmodule

// ----- design/text_glyph_blitter_5x7_top.sv -----
// Top level of the 5x7 text glyph blitter: configuration registers and the
// front end, command queue and back end. Depends on tgb_pkg and all tgb_ modules.
//
// Usage: the input channel is a queue write port (in_push / in_full). An item
// with in_func low loads the text cursor from in_pos_x / in_pos_y and gives no
// result. An item with in_func high draws in_char_code at the cursor in
// in_ink_color and moves the cursor right by six columns, saturating at 4095.
// Each lit glyph pixel inside the framebuffer becomes one pixel write on the
// output queue (out_empty / out_pop), column by column, top row first; the
// final write of a character carries out_last_pixel.
// Throughput: one pixel write per cycle from the back end while the output
// queue has room. A draw command passes the command queue, the glyph mask
// register and the pixel stage register before its writes reach the output
// queue. When the receiver stalls the output queue fills, the back end holds,
// and once the command queue is full in_full rises. Reset clears the cursor
// and the queues and sets the framebuffer to 640 by 480. cfg_we writes
// register cfg_index (0 width, 1 height) from cfg_wdata; the user must write
// it only while the block is idle; the block itself has no check for this.
module text_glyph_blitter_5x7_top #(
  parameter int MAX_FB_DIM = tgb_pkg::DEF_MAX_FB_DIM,
  parameter int CMD_DEPTH  = tgb_pkg::DEF_CMD_DEPTH,
  parameter int OUT_DEPTH  = tgb_pkg::DEF_OUT_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic                             in_func,
  input  logic [tgb_pkg::CHAR_W-1:0]       in_char_code,
  input  logic signed [tgb_pkg::CUR_W-1:0] in_pos_x,
  input  logic signed [tgb_pkg::CUR_W-1:0] in_pos_y,
  input  logic [tgb_pkg::INK_W-1:0]        in_ink_color,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [tgb_pkg::ADDR_W-1:0]       out_pixel_address,
  output logic [tgb_pkg::INK_W-1:0]        out_pixel_color,
  output logic                             out_last_pixel,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [tgb_pkg::CFG_W-1:0]        cfg_wdata
);
  import tgb_pkg::*;

  localparam int DIM_W = $clog2(MAX_FB_DIM+1);
  localparam logic [CFG_W:0] MAX_EXT = (CFG_W+1)'(MAX_FB_DIM);

  logic [CFG_W-1:0] fb_width_r, fb_width_nxt;
  logic [CFG_W-1:0] fb_height_r, fb_height_nxt;
  logic [DIM_W-1:0] fb_w, fb_h;
  cmd_t             cmd_in, cmd_out;
  logic             cmd_push, cmd_pop, cmd_full, cmd_empty;
  pix_t             pix;

  always_comb begin
    fb_width_nxt  = fb_width_r;
    fb_height_nxt = fb_height_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_WIDTH:  fb_width_nxt  = cfg_wdata;
        CFG_IDX_HEIGHT: fb_height_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_width_r  <= FB_WIDTH_RST;
      fb_height_r <= FB_HEIGHT_RST;
    end else begin
      fb_width_r  <= fb_width_nxt;
      fb_height_r <= fb_height_nxt;
    end
  end

  assign fb_w = ({1'b0, fb_width_r} > MAX_EXT) ? DIM_W'(MAX_EXT) : DIM_W'(fb_width_r);
  assign fb_h = ({1'b0, fb_height_r} > MAX_EXT) ? DIM_W'(MAX_EXT) : DIM_W'(fb_height_r);

  tgb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_func      (in_func),
    .in_char_code (in_char_code),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_ink_color (in_ink_color),
    .cmd_push     (cmd_push),
    .cmd_data     (cmd_in),
    .cmd_full     (cmd_full)
  );

  tgb_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .full  (cmd_full),
    .empty (cmd_empty),
    .count ()
  );

  tgb_back #(
    .MAX_FB_DIM (MAX_FB_DIM),
    .OUT_DEPTH  (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fb_w      (fb_w),
    .fb_h      (fb_h),
    .cmd_data  (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (pix)
  );

  assign out_pixel_address = pix.addr;
  assign out_pixel_color   = pix.color;
  assign out_last_pixel    = pix.last;

endmodule
